// ===== hw/rtl/lkt_pkg.sv =====
// Shared types and constants for the loop key time block.
`default_nettype none
package lkt_pkg;

	localparam int TIME_BITS = 32;

	typedef enum logic [2:0] {
		MODE_CLAMP    = 3'd0,
		MODE_INFINITE = 3'd1,
		MODE_REPEAT   = 3'd2,
		MODE_PINGPONG = 3'd3
	} lkt_mode_t;

	typedef enum logic [1:0] {
		ST_CONTINUE = 2'd0,
		ST_END      = 2'd1,
		ST_ERROR    = 2'd2
	} lkt_status_t;

	// Work word that travels down the divider chain.
	typedef struct packed {
		logic [2:0]           mode;
		logic                 gt;
		logic                 len_zero;
		logic [TIME_BITS-1:0] t;
		logic [TIME_BITS-1:0] len;
		logic [TIME_BITS-1:0] dvd;
		logic [TIME_BITS-1:0] rem;
		logic                 qlsb;
	} lkt_work_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lkt_in_if.sv =====
// Request channel: loop mode, elapsed time and loop length.
`default_nettype none
interface lkt_in_if import lkt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           loop_mode;
	logic [TIME_BITS-1:0] elapsed_time;
	logic [TIME_BITS-1:0] loop_length;

	modport source (output valid, output loop_mode, output elapsed_time,
		output loop_length, input ready);
	modport sink (input valid, input loop_mode, input elapsed_time,
		input loop_length, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lkt_out_if.sv =====
// Result channel: key time and status.
`default_nettype none
interface lkt_out_if import lkt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] key_time;
	logic [1:0]           status;

	modport source (output valid, output key_time, output status, input ready);
	modport sink (input valid, input key_time, input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lkt_front.sv =====
// Entry stage: registers the request and precomputes compare flags.
`default_nettype none
module lkt_front import lkt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lkt_in_if.sink     req,
	output lkt_work_t  dn_data,
	output logic       dn_valid,
	input  wire logic  dn_ready
);

	lkt_work_t work_s1;
	logic      valid_s1;
	logic      adv;

	assign adv       = !valid_s1 || dn_ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req.valid) begin
			work_s1.mode     <= req.loop_mode;
			work_s1.gt       <= req.elapsed_time > req.loop_length;
			work_s1.len_zero <= req.loop_length == '0;
			work_s1.t        <= req.elapsed_time;
			work_s1.len      <= req.loop_length;
			work_s1.dvd      <= req.elapsed_time;
			work_s1.rem      <= '0;
			work_s1.qlsb     <= 1'b0;
		end
	end

	assign dn_data  = work_s1;
	assign dn_valid = valid_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/lkt_div_step.sv =====
// One restoring division step: develops one quotient bit per stage.
`default_nettype none
module lkt_div_step import lkt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lkt_work_t  up_data,
	input  wire logic       up_valid,
	output logic            up_ready,
	output lkt_work_t       dn_data,
	output logic            dn_valid,
	input  wire logic       dn_ready
);

	lkt_work_t            work_q;
	logic                 valid_q;
	logic                 adv;
	logic [TIME_BITS:0]   trial;
	logic [TIME_BITS:0]   diff;
	logic                 fits;
	lkt_work_t            nxt;

	assign adv      = !valid_q || dn_ready;
	assign up_ready = adv;

	// Shift in the next dividend bit, subtract the divisor where it fits.
	always_comb begin
		trial = {up_data.rem, up_data.dvd[TIME_BITS-1]};
		diff  = trial - {1'b0, up_data.len};
		fits  = trial >= {1'b0, up_data.len};
		nxt      = up_data;
		nxt.dvd  = {up_data.dvd[TIME_BITS-2:0], 1'b0};
		nxt.rem  = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
		nxt.qlsb = fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			work_q <= nxt;
		end
	end

	assign dn_data  = work_q;
	assign dn_valid = valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lkt_back.sv =====
// Result stage: picks the key time per mode into the output register.
`default_nettype none
module lkt_back import lkt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lkt_work_t  up_data,
	input  wire logic       up_valid,
	output logic            up_ready,
	lkt_out_if.source       rsp
);

	logic [TIME_BITS-1:0] key_q;
	lkt_status_t          status_q;
	logic                 valid_q;
	logic                 adv;
	logic [TIME_BITS-1:0] key_n;
	lkt_status_t          status_n;
	logic [TIME_BITS-1:0] mirror;

	assign adv      = !valid_q || rsp.ready;
	assign up_ready = adv;
	assign mirror   = up_data.len - up_data.rem;

	always_comb begin
		key_n    = up_data.t;
		status_n = ST_CONTINUE;
		case (lkt_mode_t'(up_data.mode))
			MODE_CLAMP: begin
				if (up_data.gt) begin
					key_n    = up_data.len;
					status_n = ST_END;
				end
			end
			MODE_INFINITE: begin
				key_n = up_data.t;
			end
			MODE_REPEAT: begin
				if (up_data.len_zero) begin
					key_n = '0;
				end else if (up_data.gt) begin
					key_n = up_data.rem;
				end
			end
			MODE_PINGPONG: begin
				// Mirror the remainder on an odd quotient.
				if (up_data.gt) begin
					if (up_data.len_zero) begin
						key_n = '0;
					end else begin
						key_n = up_data.qlsb ? mirror : up_data.rem;
					end
				end
			end
			default: begin
				key_n    = '0;
				status_n = ST_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			key_q    <= key_n;
			status_q <= status_n;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.key_time = key_q;
	assign rsp.status   = status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/loop_key_time_core.sv =====
// Top level of the loop key time block: entry stage, divider chain, result stage.
//
// Usage:
//   req carries one query a beat: loop_mode, elapsed_time, loop_length.
//   rsp returns one beat per query, in order: key_time and status
//   (continue, end reached, bad mode).
//   The path is one entry stage, one restoring division stage per quotient
//   bit and one output register.
//   Throughput is one query per cycle while rsp is not stalled; the divider
//   chain takes a new dividend in every stage every cycle unless stalled.
//   Each stage has its own valid bit and advances when it is empty or the
//   next stage moves, so bubbles close up while rsp is stalled and req
//   keeps taking beats until the whole chain is full. A stalled rsp beat
//   holds its payload; nothing is dropped or repeated.
//   arst_n clears all valid bits at once; the block can take a beat as soon
//   as reset is released. There is no configuration.
`default_nettype none
module loop_key_time_core import lkt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	lkt_in_if.sink    req,
	lkt_out_if.source rsp
);

	lkt_work_t work   [0:TIME_BITS];
	logic      vld    [0:TIME_BITS];
	logic      rdy    [0:TIME_BITS];

	lkt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.dn_data  (work[0]),
		.dn_valid (vld[0]),
		.dn_ready (rdy[0])
	);

	for (genvar i = 0; i < TIME_BITS; i++) begin : g_step
		lkt_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_data  (work[i]),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.dn_data  (work[i+1]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1])
		);
	end

	lkt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_data  (work[TIME_BITS]),
		.up_valid (vld[TIME_BITS]),
		.up_ready (rdy[TIME_BITS]),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/lkt_checker.sv =====
// Port-level checks for the loop key time block, bound to the top level.
`default_nettype none
module lkt_checker import lkt_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_ready,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire logic [TIME_BITS-1:0] rsp_key_time,
	input wire logic [1:0]           rsp_status
);

	// A stalled result beat stays up.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_key_time) && $stable(rsp_status))
		else $error("rsp payload changed while stalled");

	// With the output register empty every stage can move, so req is open.
	a_req_open: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req blocked with empty output");

	// A bad mode always reports a zero key time.
	a_err_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_ERROR |-> rsp_key_time == '0)
		else $error("error beat with nonzero key time");

endmodule

bind loop_key_time_core lkt_checker u_lkt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_key_time (rsp.key_time),
	.rsp_status   (rsp.status)
);
`default_nettype wire
